@@ rtl/ppp_pkg.sv @@
// Package for the pinhole point projection block.
// Holds the register index codes, the status codes and the fixed port widths.
// No dependencies.
package ppp_pkg;

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int STATUS_WIDTH    = 2;
   // The translation column is in Q20.12 and the point in Q16.16.
   localparam int ONE_SHIFT       = 16;
   localparam int COEF_ONE        = 4096;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5
   } reg_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

endpackage

@@ rtl/pinhole_point_projection_top.sv @@
// Pinhole point projection: projection matrix product and pipelined division.
// Depends on ppp_pkg.
//
// One world point enters per cycle while req_stall is low. The input register,
// the row products, the row sums, the magnitudes and the overflow check take six
// stages, the restoring divider takes one stage per quotient bit for both pixels
// side by side, and the last stage clamps and holds the result beat. Every stage
// moves on as soon as the stage after it is empty or moving, so bubbles close up
// behind a stall. The projection matrix is written through the csr port; the user
// must write it only while the block is idle, which the block does not enforce.
module pinhole_point_projection_top #(
   parameter int COEF_WIDTH  = 32,
   parameter int COORD_WIDTH = 32,
   parameter int PIXEL_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_world_x,
   input  logic signed [COORD_WIDTH-1:0]         req_world_y,
   input  logic signed [COORD_WIDTH-1:0]         req_world_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [PIXEL_WIDTH-1:0]         rsp_pixel_u,
   output logic signed [PIXEL_WIDTH-1:0]         rsp_pixel_v,
   output logic [ppp_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input  logic                                  csr_we,
   input  logic [ppp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ppp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int DW     = SUM_W + PIXEL_WIDTH;
   localparam int NST    = PIXEL_WIDTH + 7;
   localparam int S_DIV  = 6;
   localparam int S_OUT  = NST - 1;
   localparam int HALF   = ppp_pkg::CSR_DATA_WIDTH / 2;

   // Coefficient registers, row major.
   logic signed [COEF_WIDTH-1:0] coef_ff [3][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               coef_ff[r][c] <= (r == c) ? COEF_WIDTH'(ppp_pkg::COEF_ONE) : '0;
            end
         end
      end else if (csr_we) begin
         case (csr_index)
            ppp_pkg::REG_ROW0_COLS01, ppp_pkg::REG_ROW0_COLS23,
            ppp_pkg::REG_ROW1_COLS01, ppp_pkg::REG_ROW1_COLS23,
            ppp_pkg::REG_ROW2_COLS01, ppp_pkg::REG_ROW2_COLS23: begin
               coef_ff[csr_index[2:1]][{csr_index[0], 1'b0}] <=
                  csr_wdata[COEF_WIDTH-1:0];
               coef_ff[csr_index[2:1]][{csr_index[0], 1'b1}] <=
                  csr_wdata[HALF +: COEF_WIDTH];
            end
            default: begin
            end
         endcase
      end
   end

   // Flow control: a stage loads when it is empty or its contents move on.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] ok;

   always_comb begin
      ok[NST-1] = !valid_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         ok[k] = !valid_ff[k] || ok[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ok[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (ok[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !ok[0];
   assign rsp_valid = valid_ff[S_OUT];

   // Stage 0: input point.
   logic signed [COORD_WIDTH-1:0] pt_ff [3];
   // Stage 1: products and translation terms.
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [SUM_W-1:0]  trans_ff [3];
   // Stage 2: partial sums. Stage 3: row sums.
   logic signed [SUM_W-1:0]  part_a_ff [3];
   logic signed [SUM_W-1:0]  part_b_ff [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   // Stage 4: magnitudes and signs.
   logic [SUM_W-1:0] mag_ff [3];
   logic [2:0]       neg_ff;
   logic             zero4_ff;

   always_ff @(posedge clock) begin
      if (ok[0]) begin
         pt_ff[0] <= req_world_x;
         pt_ff[1] <= req_world_y;
         pt_ff[2] <= req_world_z;
      end
      if (ok[1]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PROD_W'(coef_ff[r][c]) * PROD_W'(pt_ff[c]);
            end
            trans_ff[r] <= SUM_W'(coef_ff[r][3]) <<< ppp_pkg::ONE_SHIFT;
         end
      end
      if (ok[2]) begin
         for (int r = 0; r < 3; r++) begin
            part_a_ff[r] <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]);
            part_b_ff[r] <= SUM_W'(prod_ff[r][2]) + trans_ff[r];
         end
      end
      if (ok[3]) begin
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= part_a_ff[r] + part_b_ff[r];
         end
      end
      if (ok[4]) begin
         for (int r = 0; r < 3; r++) begin
            neg_ff[r] <= sum_ff[r][SUM_W-1];
            mag_ff[r] <= sum_ff[r][SUM_W-1] ? SUM_W'(-sum_ff[r]) : SUM_W'(sum_ff[r]);
         end
         zero4_ff <= (sum_ff[2] == '0);
      end
   end

   // Stage 5 fills entry 0; divider step j fills entry j + 1.
   logic [DW-1:0]          rem_ff  [2][PIXEL_WIDTH+1];
   logic [PIXEL_WIDTH-1:0] quo_ff  [2][PIXEL_WIDTH+1];
   logic [1:0]             qneg_ff [PIXEL_WIDTH+1];
   logic [1:0]             over_ff [PIXEL_WIDTH+1];
   logic [SUM_W-1:0]       den_ff  [PIXEL_WIDTH+1];
   logic                   zero_ff [PIXEL_WIDTH+1];

   always_ff @(posedge clock) begin
      if (ok[5]) begin
         for (int p = 0; p < 2; p++) begin
            rem_ff[p][0]  <= DW'(mag_ff[p]);
            quo_ff[p][0]  <= '0;
            qneg_ff[0][p] <= neg_ff[p] ^ neg_ff[2];
            // A quotient of 2**PIXEL_WIDTH or more saturates either way.
            over_ff[0][p] <= DW'(mag_ff[p]) >= (DW'(mag_ff[2]) << PIXEL_WIDTH);
         end
         den_ff[0]  <= mag_ff[2];
         zero_ff[0] <= zero4_ff;
      end
      for (int j = 0; j < PIXEL_WIDTH; j++) begin
         if (ok[S_DIV+j]) begin
            for (int p = 0; p < 2; p++) begin
               if (rem_ff[p][j] >= (DW'(den_ff[j]) << (PIXEL_WIDTH - 1 - j))) begin
                  rem_ff[p][j+1] <= rem_ff[p][j] - (DW'(den_ff[j]) << (PIXEL_WIDTH - 1 - j));
                  quo_ff[p][j+1] <= quo_ff[p][j] | (PIXEL_WIDTH'(1) << (PIXEL_WIDTH - 1 - j));
               end else begin
                  rem_ff[p][j+1] <= rem_ff[p][j];
                  quo_ff[p][j+1] <= quo_ff[p][j];
               end
            end
            qneg_ff[j+1] <= qneg_ff[j];
            over_ff[j+1] <= over_ff[j];
            den_ff[j+1]  <= den_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   // Output stage: sign, clamp and status.
   localparam logic [PIXEL_WIDTH-1:0] LIM_POS = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
   localparam logic [PIXEL_WIDTH-1:0] LIM_NEG = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

   logic [PIXEL_WIDTH-1:0] pix_in [2];
   logic [1:0]             sat_in;
   logic [PIXEL_WIDTH-1:0] pix_ff [2];
   ppp_pkg::status_type    status_in;
   ppp_pkg::status_type    status_ff;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         if (!qneg_ff[PIXEL_WIDTH][p]) begin
            sat_in[p] = over_ff[PIXEL_WIDTH][p] || (quo_ff[p][PIXEL_WIDTH] > LIM_POS);
            pix_in[p] = sat_in[p] ? LIM_POS : quo_ff[p][PIXEL_WIDTH];
         end else begin
            sat_in[p] = over_ff[PIXEL_WIDTH][p] || (quo_ff[p][PIXEL_WIDTH] > LIM_NEG);
            pix_in[p] = sat_in[p] ? LIM_NEG : PIXEL_WIDTH'(-quo_ff[p][PIXEL_WIDTH]);
         end
      end
      if (zero_ff[PIXEL_WIDTH]) begin
         pix_in[0] = '0;
         pix_in[1] = '0;
         status_in = ppp_pkg::STATUS_ZERO;
      end else if (sat_in != 2'b00) begin
         status_in = ppp_pkg::STATUS_SAT;
      end else begin
         status_in = ppp_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (ok[S_OUT]) begin
         pix_ff[0] <= pix_in[0];
         pix_ff[1] <= pix_in[1];
         status_ff <= status_in;
      end
   end

   assign rsp_pixel_u = pix_ff[0];
   assign rsp_pixel_v = pix_ff[1];
   assign rsp_status  = status_ff;

`ifndef NO_ASSERTIONS
   a_zero_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_ff == ppp_pkg::STATUS_ZERO |-> pix_ff[0] == '0 && pix_ff[1] == '0)
      else $error("zero depth result with nonzero pixels");
   a_empty_entry: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("input stalled with an empty entry stage");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> valid_ff[S_OUT] && $stable(pix_ff[0]) && $stable(status_ff))
      else $error("result beat lost under stall");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_OUT-1] && !ok[S_OUT] |=> valid_ff[S_OUT-1])
      else $error("divider beat dropped while blocked");
`endif

endmodule

@@ tb/pinhole_point_projection_top_tb.sv @@
// Testbench for pinhole_point_projection_top: drives world points, predicts every pixel
// beat from its own copy of the projection matrix, and checks each result in order.
// Depends on ppp_pkg and the block's RTL.
`timescale 1ns / 100ps

module pinhole_point_projection_top_tb;

   localparam int PIXEL_W    = 16;
   localparam int DRAIN_WAIT = 40;    // more than the number of pipeline stages
   localparam int IDLE_LIMIT = 5000;
   localparam logic [ppp_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [ppp_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [PIXEL_W-1:0] u;
      logic signed [PIXEL_W-1:0] v;
      ppp_pkg::status_type       status;
   } pixel_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic signed [31:0] req_world_x = '0;
   logic signed [31:0] req_world_y = '0;
   logic signed [31:0] req_world_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [PIXEL_W-1:0] rsp_pixel_u;
   logic signed [PIXEL_W-1:0] rsp_pixel_v;
   logic [ppp_pkg::STATUS_WIDTH-1:0]   rsp_status;
   logic        csr_we = 1'b0;
   logic [ppp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [ppp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   pinhole_point_projection_top i_dut (.*);

   always #5 clock = ~clock;

   logic [63:0] matrix_regs [0:5];
   pixel_beat_type pending_pixels [$];
   int errors = 0;
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int hold_off_cycles = 0;
   int rx_wait = 0;
   int quiet_cycles = 0;

   function automatic logic signed [PIXEL_W-1:0] clamp_pixel(
         input logic signed [127:0] q, output bit hit);
      hit = 1'b0;
      if (q > 128'sd32767) begin
         hit = 1'b1;
         return 16'sh7fff;
      end
      if (q < -128'sd32768) begin
         hit = 1'b1;
         return 16'sh8000;
      end
      return q[PIXEL_W-1:0];
   endfunction

   function automatic pixel_beat_type project_point(input logic signed [31:0] x, y, z);
      logic signed [127:0] sum [0:2];
      logic signed [127:0] c0, c1, c2, c3, px, py, pz;
      pixel_beat_type r;
      bit hit_u, hit_v;
      px = x;
      py = y;
      pz = z;
      for (int row = 0; row < 3; row++) begin
         c0 = $signed(matrix_regs[2*row][31:0]);
         c1 = $signed(matrix_regs[2*row][63:32]);
         c2 = $signed(matrix_regs[2*row+1][31:0]);
         c3 = $signed(matrix_regs[2*row+1][63:32]);
         sum[row] = c0 * px + c1 * py + c2 * pz + (c3 <<< ppp_pkg::ONE_SHIFT);
      end
      if (sum[2] == 0) begin
         r.u = '0;
         r.v = '0;
         r.status = ppp_pkg::STATUS_ZERO;
      end else begin
         // SystemVerilog signed division truncates toward zero, as the block does.
         r.u = clamp_pixel(sum[0] / sum[2], hit_u);
         r.v = clamp_pixel(sum[1] / sum[2], hit_v);
         r.status = (hit_u || hit_v) ? ppp_pkg::STATUS_SAT : ppp_pkg::STATUS_OK;
      end
      return r;
   endfunction

   task automatic send_point(input logic signed [31:0] x, y, z);
      int gap;
      gap = tx_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_world_x <= x;
      req_world_y <= y;
      req_world_z <= z;
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(project_point(x, y, z));
   endtask

   // Lowers valid and waits until every beat is back and the pipeline has emptied.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Each write raises the enable, then lowers it and waits again before returning.
   task automatic write_reg(input logic [ppp_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx <= ppp_pkg::REG_ROW2_COLS23) matrix_regs[idx] = data;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      return $urandom();
   endfunction

   function automatic logic [63:0] pack_coefs(input logic [31:0] lo, hi);
      return {hi, lo};
   endfunction

   // A plausible camera: focal lengths and principal point, small rotation terms.
   task automatic load_camera();
      logic [31:0] fx, fy, cx, cy, jitter;
      fx = $urandom_range(100, 2000) * ppp_pkg::COEF_ONE;
      fy = $urandom_range(100, 2000) * ppp_pkg::COEF_ONE;
      cx = $urandom_range(0, 1000) * ppp_pkg::COEF_ONE;
      cy = $urandom_range(0, 800) * ppp_pkg::COEF_ONE;
      jitter = $urandom_range(0, 400) - 200;
      write_reg(ppp_pkg::REG_ROW0_COLS01, pack_coefs(fx, jitter * 20));
      write_reg(ppp_pkg::REG_ROW0_COLS23,
                pack_coefs(cx, $urandom_range(0, 100000) - 50000));
      write_reg(ppp_pkg::REG_ROW1_COLS01, pack_coefs(-jitter * 20, fy));
      write_reg(ppp_pkg::REG_ROW1_COLS23,
                pack_coefs(cy, $urandom_range(0, 100000) - 50000));
      write_reg(ppp_pkg::REG_ROW2_COLS01,
                pack_coefs(jitter, $urandom_range(0, 400) - 200));
      write_reg(ppp_pkg::REG_ROW2_COLS23,
                pack_coefs(ppp_pkg::COEF_ONE, $urandom_range(0, 8192) - 4096));
   endtask

   task automatic send_random_point();
      if ($urandom_range(0, 9) < 7)
         send_point($urandom_range(0, 20 << 16) - (10 << 16),
                    $urandom_range(0, 20 << 16) - (10 << 16),
                    $urandom_range(1 << 12, 50 << 16));
      else
         send_point(rand_word(), rand_word(), rand_word());
   endtask

   task automatic write_all(input logic [63:0] data);
      for (int idx = ppp_pkg::REG_ROW0_COLS01; idx <= ppp_pkg::REG_ROW2_COLS23; idx++)
         write_reg(ppp_pkg::CSR_INDEX_WIDTH'(idx), data);
   endtask

   task automatic test_identity_points();
      send_point(0, 0, 0);
      send_point(32'sd1 << 16, 32'sd2 << 16, 32'sd1 << 16);
      send_point(32'sh7fffffff, 32'sh80000000, 1);
      send_point(32'sh80000000, 32'sh7fffffff, -1);
      send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_point(32'sh80000000, 0, -1);
      send_point(32767, -32768, 1);
      send_point(32768, -32769, 1);
      send_point(7, -7, -2);
      send_point(-5 << 16, 7 << 16, 2 << 16);
      send_point(100, -100, 0);
      settle();
   endtask

   task automatic test_matrix_extremes();
      write_all('0);
      send_point(32'sh12345678, -3, 9);
      settle();
      write_all('1);
      send_point(32'sh7fffffff, 32'sh80000000, 5);
      send_point(1, 2, 3);
      send_point(-1, 0, 1);
      settle();
      write_all(64'h80000000_80000000);
      send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      send_point(0, 0, 0);
      settle();
      write_all(64'h7fffffff_7fffffff);
      // Writes to the spare indexes must leave the matrix alone.
      write_reg(REG_SPARE_6, '0);
      write_reg(REG_SPARE_7, '1);
      send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_point(rand_word(), rand_word(), rand_word());
      settle();
   endtask

   task automatic test_random_cameras();
      for (int cam = 0; cam < 5; cam++) begin
         load_camera();
         tx_idle = (cam != 2);
         rx_idle = (cam != 3);
         repeat (150) send_random_point();
         settle();
      end
      for (int idx = ppp_pkg::REG_ROW0_COLS01; idx <= ppp_pkg::REG_ROW2_COLS23; idx++)
         write_reg(ppp_pkg::CSR_INDEX_WIDTH'(idx), {rand_word(), rand_word()});
      repeat (60) send_point(rand_word(), rand_word(), rand_word());
      settle();
   endtask

   task automatic test_backpressure();
      load_camera();
      tx_idle = 1'b0;
      hold_off_cycles = 300;
      repeat (80) send_random_point();
      tx_idle = 1'b1;
      // The sender waits here until every beat is back, then carries on.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) send_random_point();
      settle();
   endtask

   always @(posedge clock) begin
      pixel_beat_type want;
      if (rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: result beat with nothing expected: u %0d v %0d status %0d",
                     $time, rsp_pixel_u, rsp_pixel_v, rsp_status);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_u !== want.u) begin
               $display("%0t: pixel_u expected %0d actual %0d", $time, want.u, rsp_pixel_u);
               errors++;
            end
            if (rsp_pixel_v !== want.v) begin
               $display("%0t: pixel_v expected %0d actual %0d", $time, want.v, rsp_pixel_v);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
         end
         rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
      end
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else if (rx_wait > 0) begin
         rsp_stall <= 1'b1;
         rx_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      matrix_regs[0] = 64'd4096;
      matrix_regs[1] = 64'd0;
      matrix_regs[2] = 64'd4096 << 32;
      matrix_regs[3] = 64'd0;
      matrix_regs[4] = 64'd0;
      matrix_regs[5] = 64'd4096;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_points();
      test_matrix_extremes();
      test_random_cameras();
      test_backpressure();
      errors += pending_pixels.size();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
